### src/gbn_pkg.sv
// Shared types, constants and codes for the go-back-N sender.
package gbn_pkg;

  localparam int MAX_FRAMES  = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam int CMDQ_DEPTH  = 2;

  localparam int FIDX_W = $clog2(MAX_FRAMES);
  localparam int FCNT_W = $clog2(MAX_FRAMES + 1);
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CQP_W  = $clog2(CMDQ_DEPTH);
  localparam int CQC_W  = $clog2(CMDQ_DEPTH + 1);
  localparam int SEQ_W  = 4;
  localparam int NSEQ_W = 5;
  localparam int TMR_W  = 11;

  localparam logic [TMR_W-1:0] TIMER_MAX    = 11'd2047;
  localparam logic [7:0]       ACK_CHAR     = 8'h06;
  localparam logic [7:0]       FIRST_LETTER = 8'h41;

  // action field codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // classified command kinds
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_MSG_LEN       = 3'd0;
  localparam logic [2:0] CFG_SEQ_MAX       = 3'd1;
  localparam logic [2:0] CFG_SEND_INTERVAL = 3'd2;
  localparam logic [2:0] CFG_ACK_TIMEOUT   = 3'd3;
  localparam logic [2:0] CFG_ACK_HOLD      = 3'd4;
  localparam logic [2:0] CFG_WINDOW_LIMIT  = 3'd5;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] ack_seq;
    logic             ack_pos;
  } gbn_cmd_t;

  typedef struct packed {
    logic [5:0] msg_len;
    logic [3:0] seq_max;
    logic [7:0] send_interval;
    logic [9:0] ack_timeout;
    logic [4:0] ack_hold;
    logic [4:0] window_limit;
  } gbn_cfg_t;

  typedef struct packed {
    logic       send_valid;
    logic [4:0] frame_index;
    logic [3:0] frame_seq;
    logic [7:0] frame_byte;
    logic [4:0] outstanding;
    logic       running;
    logic       all_sent;
    logic       queue_overflow;
  } gbn_res_t;

endpackage

### src/go_back_n_sender.sv
// Go-back-N ARQ sender. Each input word is one event: start (send frame 0 of a
// msg_len frame message), a received ack (a positive ack matching the oldest
// outstanding sequence retires it) or a time tick (advances the send and ack
// timers, sends the next frame when send_interval is exceeded, or goes back
// and resends from the oldest unacked frame when ack_timeout is exceeded).
// Every input word yields exactly one result word with the frame sent, if any,
// and the status after the event. The block takes one word per clock cycle
// while the result side keeps up; an accepted input word is first written
// into the two-entry command queue, and from the head of that queue the
// state update computes its result word, which lands in the result register.
// A stalled result holds the back end; the command queue then fills its
// two entries and stalls the input. No clearing pass is needed after reset.
// Write the configuration registers only while no event is in flight.
module go_back_n_sender import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_ack_seq,
  input  logic [7:0] in_ack_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_send_valid,
  output logic [4:0] out_frame_index,
  output logic [3:0] out_frame_seq,
  output logic [7:0] out_frame_byte,
  output logic [4:0] out_outstanding,
  output logic       out_running,
  output logic       out_all_sent,
  output logic       out_queue_overflow
);

  gbn_cfg_t cfg_r;
  gbn_cmd_t cmd;
  logic     cmd_valid, cmd_take;
  gbn_res_t res;

  // Hold the configuration registers; writes to unused indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.msg_len       <= 6'd26;
      cfg_r.seq_max       <= 4'd15;
      cfg_r.send_interval <= 8'd10;
      cfg_r.ack_timeout   <= 10'd100;
      cfg_r.ack_hold      <= 5'd3;
      cfg_r.window_limit  <= 5'd15;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MSG_LEN:       cfg_r.msg_len       <= cfg_data[5:0];
        CFG_SEQ_MAX:       cfg_r.seq_max       <= cfg_data[3:0];
        CFG_SEND_INTERVAL: cfg_r.send_interval <= cfg_data[7:0];
        CFG_ACK_TIMEOUT:   cfg_r.ack_timeout   <= cfg_data[9:0];
        CFG_ACK_HOLD:      cfg_r.ack_hold      <= cfg_data[4:0];
        CFG_WINDOW_LIMIT:  cfg_r.window_limit  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Front: take the input word, classify it, park it in the command queue.
  gbn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_ack_seq  (in_ack_seq),
    .in_ack_code (in_ack_code),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // Back: advance the sender state and register the result word.
  gbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (out_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  assign out_send_valid     = res.send_valid;
  assign out_frame_index    = res.frame_index;
  assign out_frame_seq      = res.frame_seq;
  assign out_frame_byte     = res.frame_byte;
  assign out_outstanding    = res.outstanding;
  assign out_running        = res.running;
  assign out_all_sent       = res.all_sent;
  assign out_queue_overflow = res.queue_overflow;

endmodule

### src/gbn_front.sv
// Front end: accepts input words, classifies them and queues commands.
module gbn_front import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [3:0] in_ack_seq,
  input  logic [7:0] in_ack_code,
  output logic       cmd_valid,
  output gbn_cmd_t   cmd,
  input  logic       cmd_take
);

  gbn_cmd_t         q_r [CMDQ_DEPTH];
  logic [CQP_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CQC_W-1:0] cnt_r;
  gbn_cmd_t         cls;
  logic             push;

  always_comb begin
    cls.ack_seq = in_ack_seq;
    cls.ack_pos = (in_ack_code == ACK_CHAR);
    unique case (in_action)
      ACT_START: cls.kind = CMD_START;
      ACT_ACK:   cls.kind = CMD_ACK;
      ACT_TICK:  cls.kind = CMD_TICK;
      ACT_NONE:  cls.kind = CMD_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == CQC_W'(CMDQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == CQP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (cmd_take) begin
        rd_ptr_r <= (rd_ptr_r == CQP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CQC_W'(push) - CQC_W'(cmd_take);
    end
  end

endmodule

### src/gbn_back.sv
// Back end: sender state, frame bookkeeping and the registered result word.
module gbn_back import gbn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  gbn_cfg_t cfg,
  input  logic     cmd_valid,
  input  gbn_cmd_t cmd,
  output logic     cmd_take,
  output logic     res_valid,
  output gbn_res_t res,
  input  logic     res_stall
);

  logic [NSEQ_W-1:0] next_seq_r, next_seq_nxt;
  logic [FCNT_W-1:0] frames_sent_r, frames_sent_nxt;
  logic [TMR_W-1:0]  send_timer_r, send_timer_nxt;
  logic [TMR_W-1:0]  ack_timer_r, ack_timer_nxt;
  logic              active_r, active_nxt;
  logic              last_sent_r, last_sent_nxt;
  logic [QIDX_W-1:0] head_r, head_nxt;
  logic [QCNT_W-1:0] qcount_r, qcount_nxt;
  logic              res_valid_r, res_valid_nxt;
  gbn_res_t          res_r, res_nxt;

  logic [SEQ_W-1:0]  seq_tab [MAX_FRAMES];
  logic [SEQ_W-1:0]  pend_q  [QUEUE_DEPTH];

  logic              tab_we, pq_we;
  logic [FIDX_W-1:0] tab_addr;
  logic [SEQ_W-1:0]  tab_data;
  logic [QIDX_W-1:0] pq_addr;
  logic [SEQ_W-1:0]  pq_data;

  logic [FCNT_W-1:0] len;
  logic [QCNT_W-1:0] cap;
  logic              sent, dropped, enq, hold_chk;
  logic [FIDX_W-1:0] idx;
  logic [SEQ_W-1:0]  seq;
  logic [NSEQ_W-1:0] ns0;
  logic [FCNT_W-1:0] base;
  logic [QIDX_W:0]   pos;

  assign cmd_take = cmd_valid && (!res_valid_r || !res_stall);

  always_comb begin
    if (cfg.msg_len == '0) begin
      len = FCNT_W'(1);
    end else if (cfg.msg_len > MAX_FRAMES) begin
      len = FCNT_W'(MAX_FRAMES);
    end else begin
      len = FCNT_W'(cfg.msg_len);
    end
    cap = (cfg.window_limit > QUEUE_DEPTH) ? QCNT_W'(QUEUE_DEPTH) : QCNT_W'(cfg.window_limit);
  end

  always_comb begin
    next_seq_nxt    = next_seq_r;
    frames_sent_nxt = frames_sent_r;
    send_timer_nxt  = send_timer_r;
    ack_timer_nxt   = ack_timer_r;
    active_nxt      = active_r;
    last_sent_nxt   = last_sent_r;
    head_nxt        = head_r;
    qcount_nxt      = qcount_r;
    sent     = 1'b0;
    dropped  = 1'b0;
    enq      = 1'b0;
    hold_chk = 1'b0;
    idx      = '0;
    seq      = '0;
    ns0      = '0;
    base     = '0;
    pos      = '0;
    tab_we   = 1'b0;
    tab_addr = '0;
    tab_data = '0;
    pq_we    = 1'b0;
    pq_addr  = '0;
    pq_data  = '0;

    unique case (cmd.kind)
      CMD_START: begin
        if (!active_r) begin
          head_nxt        = '0;
          qcount_nxt      = '0;
          send_timer_nxt  = '0;
          ack_timer_nxt   = '0;
          active_nxt      = 1'b1;
          tab_we          = 1'b1;
          next_seq_nxt    = NSEQ_W'(1);
          frames_sent_nxt = FCNT_W'(1);
          sent            = 1'b1;
          enq             = 1'b1;
        end
      end
      CMD_ACK: begin
        // retire the oldest frame on a matching positive ack
        if (active_r && cmd.ack_pos && qcount_r != '0 && pend_q[head_r] == cmd.ack_seq) begin
          qcount_nxt    = qcount_r - 1'b1;
          head_nxt      = (head_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          ack_timer_nxt = '0;
        end
      end
      CMD_TICK: begin
        if (active_r) begin
          send_timer_nxt = (send_timer_r >= TIMER_MAX) ? TIMER_MAX : send_timer_r + 1'b1;
          ack_timer_nxt  = (ack_timer_r >= TIMER_MAX) ? TIMER_MAX : ack_timer_r + 1'b1;
          if (send_timer_nxt > TMR_W'(cfg.send_interval) && frames_sent_r < len) begin
            send_timer_nxt  = '0;
            ns0             = (next_seq_r > NSEQ_W'(cfg.seq_max)) ? '0 : next_seq_r;
            idx             = frames_sent_r[FIDX_W-1:0];
            seq             = ns0[SEQ_W-1:0];
            tab_we          = 1'b1;
            tab_addr        = idx;
            tab_data        = seq;
            next_seq_nxt    = ns0 + 1'b1;
            frames_sent_nxt = frames_sent_r + 1'b1;
            sent            = 1'b1;
            enq             = 1'b1;
            hold_chk        = 1'b1;
          end else if (ack_timer_nxt > TMR_W'(cfg.ack_timeout)) begin
            send_timer_nxt = '0;
            ack_timer_nxt  = '0;
            if (qcount_r != '0) begin
              // go back to the oldest unacked frame and resend it
              base = (FCNT_W'(qcount_r) > frames_sent_r) ? '0
                                                         : frames_sent_r - FCNT_W'(qcount_r);
              idx             = base[FIDX_W-1:0];
              seq             = seq_tab[idx];
              next_seq_nxt    = NSEQ_W'(seq) + 1'b1;
              frames_sent_nxt = FCNT_W'(idx) + 1'b1;
              head_nxt        = '0;
              qcount_nxt      = '0;
              sent            = 1'b1;
              enq             = 1'b1;
            end
          end
        end
      end
      CMD_NOP: begin
      end
    endcase

    if (enq) begin
      if (qcount_nxt >= cap) begin
        dropped = 1'b1;
      end else begin
        pos = {1'b0, head_nxt} + (QIDX_W + 1)'(qcount_nxt);
        if (pos >= (QIDX_W + 1)'(QUEUE_DEPTH)) begin
          pos = pos - (QIDX_W + 1)'(QUEUE_DEPTH);
        end
        pq_we      = 1'b1;
        pq_addr    = pos[QIDX_W-1:0];
        pq_data    = seq;
        qcount_nxt = qcount_nxt + 1'b1;
      end
    end
    if (hold_chk && qcount_nxt <= QCNT_W'(cfg.ack_hold)) begin
      ack_timer_nxt = '0;
    end

    if (active_nxt) begin
      last_sent_nxt = (frames_sent_nxt >= len);
      if (cmd.kind == CMD_ACK && qcount_nxt == '0 && last_sent_nxt) begin
        active_nxt = 1'b0;
      end
    end

    res_nxt.send_valid     = sent;
    res_nxt.frame_index    = 5'(idx);
    res_nxt.frame_seq      = seq;
    res_nxt.frame_byte     = sent ? (FIRST_LETTER + 8'(idx)) : 8'd0;
    res_nxt.outstanding    = 5'(qcount_nxt);
    res_nxt.running        = active_nxt;
    res_nxt.all_sent       = last_sent_nxt;
    res_nxt.queue_overflow = dropped;

    if (cmd_take) begin
      res_valid_nxt = 1'b1;
    end else if (res_stall) begin
      res_valid_nxt = res_valid_r;
    end else begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && tab_we) begin
      seq_tab[tab_addr] <= tab_data;
    end
    if (cmd_take && pq_we) begin
      pend_q[pq_addr] <= pq_data;
    end
    if (cmd_take) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r    <= '0;
      frames_sent_r <= '0;
      send_timer_r  <= '0;
      ack_timer_r   <= '0;
      active_r      <= 1'b0;
      last_sent_r   <= 1'b0;
      head_r        <= '0;
      qcount_r      <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (cmd_take) begin
        next_seq_r    <= next_seq_nxt;
        frames_sent_r <= frames_sent_nxt;
        send_timer_r  <= send_timer_nxt;
        ack_timer_r   <= ack_timer_nxt;
        active_r      <= active_nxt;
        last_sent_r   <= last_sent_nxt;
        head_r        <= head_nxt;
        qcount_r      <= qcount_nxt;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### src/gbn_checker.sv
// Port-level checker for the go-back-N sender, bound to the top level.
module gbn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic [2:0] cfg_idx,
  input logic [9:0] cfg_data,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_action,
  input logic [3:0] in_ack_seq,
  input logic [7:0] in_ack_code,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_send_valid,
  input logic [4:0] out_frame_index,
  input logic [3:0] out_frame_seq,
  input logic [7:0] out_frame_byte,
  input logic [4:0] out_outstanding,
  input logic       out_running,
  input logic       out_all_sent,
  input logic       out_queue_overflow
);

  // no frame: frame fields are zero
  a_idle_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_send_valid) |->
      (out_frame_index == 5'd0 && out_frame_seq == 4'd0 && out_frame_byte == 8'd0))
    else $error("frame fields set without a sent frame");

  // payload letter follows the frame index
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_valid) |->
      (out_frame_byte == 8'(8'h41 + {3'b000, out_frame_index})))
    else $error("frame byte does not match frame index");

  // a stopped sender has nothing outstanding and sends nothing
  a_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running) |-> (out_outstanding == 5'd0 && !out_send_valid))
    else $error("stopped sender reports traffic");

  // a dropped enqueue belongs to a sent frame
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_queue_overflow) |-> out_send_valid)
    else $error("overflow without a sent frame");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_frame_index) && $stable(out_outstanding) &&
       $stable(out_send_valid) && $stable(out_running)))
    else $error("stalled result word changed");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);
